// ===== hdl/divisor_count_minus_one_core_assert.svh =====
// Assertion macros for the divisor counter checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef DIVISOR_COUNT_MINUS_ONE_CORE_ASSERT_SVH
`define DIVISOR_COUNT_MINUS_ONE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCMO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DCMO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dcmo_pkg.sv =====
// Shared types and constants of the divisor counter.
// Depends on nothing; used by the result interface, the core and its checker.
package dcmo_pkg;

    localparam int RESULT_BITS = 14;
    // The running product is held one bit wider so it can saturate at 2**RESULT_BITS.
    localparam int PROD_BITS = RESULT_BITS + 1;
    localparam logic [PROD_BITS-1:0] PRODUCT_CAP = PROD_BITS'(1) << RESULT_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DECIDE,
        ST_DONE
    } state_t;

endpackage

// ===== hdl/dcmo_value_if.sv =====
// Input channel of the divisor counter: one value per word.
// Depends on nothing.
interface dcmo_value_if #(
    parameter int VALUE_BITS = 40
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

// ===== hdl/dcmo_result_if.sv =====
// Output channel of the divisor counter: one divisor count per word.
// Depends on dcmo_pkg for the result width.
interface dcmo_result_if;
    logic                            valid;
    logic                            ready;
    logic [dcmo_pkg::RESULT_BITS-1:0] divisors_less_one;

    modport source (output valid, output divisors_less_one, input ready);
    modport sink (input valid, input divisors_less_one, output ready);
endinterface

// ===== hdl/divisor_count_minus_one_core.sv =====
// Channel    Dir  Payload                     Meaning
// operand    in   value [VALUE_BITS-1:0]      number whose divisors are counted
// result     out  divisors_less_one [13:0]    divisor count minus one, saturated
//
// One shared restoring divider produces quotient and remainder one bit per cycle;
// each trial division in ST_DIVIDE is followed by a decision in ST_DECIDE.
// operand.ready is high only while idle; the result waits in its register until taken.
// Reset is asynchronous and active low and clears only the sequencer state.
module divisor_count_minus_one_core #(
    parameter int VALUE_BITS = 40
) (
    input logic          clk,
    input logic          rst_n,
    dcmo_value_if.sink   operand,
    dcmo_result_if.source result
);

    localparam int D_BITS   = VALUE_BITS / 2 + 2;
    localparam int R_BITS   = D_BITS + 1;
    localparam int EXP_BITS = $clog2(VALUE_BITS + 1);
    localparam int CNT_BITS = $clog2(VALUE_BITS);
    localparam int PB       = dcmo_pkg::PROD_BITS;

    dcmo_pkg::state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] qn_reg, qn_next;
    logic [R_BITS-1:0]     acc_reg, acc_next;
    logic [D_BITS-1:0]     d_reg, d_next;
    logic [EXP_BITS-1:0]   exp_reg, exp_next;
    logic [PB-1:0]         prod_reg, prod_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  inner_reg, inner_next;

    logic [R_BITS-1:0]       shifted;
    logic [R_BITS-1:0]       diff;
    logic                    q_bit;
    logic [VALUE_BITS-1:0]   d_ext;
    logic [D_BITS-1:0]       d_following;
    logic [EXP_BITS-1:0]     factor;
    logic [PB+EXP_BITS-1:0]  prod_wide;
    logic [PB-1:0]           prod_scaled;
    logic [PB-1:0]           prod_less_one;

    // One step of the restoring divider.
    assign shifted = {acc_reg[R_BITS-2:0], qn_reg[VALUE_BITS-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign q_bit   = (shifted >= {1'b0, d_reg});

    assign d_ext       = {{(VALUE_BITS - D_BITS){1'b0}}, d_reg};
    assign d_following = (d_reg == D_BITS'(2)) ? D_BITS'(3) : d_reg + D_BITS'(2);

    // Inside a divide-out run the factor is exponent plus one; at the end a
    // leftover prime contributes a factor of two.
    assign factor      = inner_reg ? exp_reg + EXP_BITS'(1) : EXP_BITS'(2);
    assign prod_wide   = prod_reg * factor;
    assign prod_scaled = (prod_wide >= (PB + EXP_BITS)'(dcmo_pkg::PRODUCT_CAP))
                         ? dcmo_pkg::PRODUCT_CAP : prod_wide[PB-1:0];

    assign prod_less_one            = prod_reg - PB'(1);
    assign result.divisors_less_one = prod_less_one[dcmo_pkg::RESULT_BITS-1:0];
    assign result.valid             = (state_reg == dcmo_pkg::ST_DONE);
    assign operand.ready            = (state_reg == dcmo_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        qn_next    = qn_reg;
        acc_next   = acc_reg;
        d_next     = d_reg;
        exp_next   = exp_reg;
        prod_next  = prod_reg;
        cnt_next   = cnt_reg;
        inner_next = inner_reg;

        case (state_reg)
            dcmo_pkg::ST_IDLE:
            begin
                if (operand.valid)
                begin
                    rem_next   = operand.value;
                    qn_next    = operand.value;
                    acc_next   = '0;
                    cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                    d_next     = D_BITS'(2);
                    exp_next   = '0;
                    prod_next  = PB'(1);
                    inner_next = 1'b0;
                    state_next = dcmo_pkg::ST_DIVIDE;
                end
            end
            dcmo_pkg::ST_DIVIDE:
            begin
                acc_next = q_bit ? diff : shifted;
                qn_next  = {qn_reg[VALUE_BITS-2:0], q_bit};
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == '0)
                begin
                    state_next = dcmo_pkg::ST_DECIDE;
                end
            end
            dcmo_pkg::ST_DECIDE:
            begin
                // qn_reg holds the quotient and acc_reg the remainder.
                acc_next   = '0;
                cnt_next   = CNT_BITS'(VALUE_BITS - 1);
                state_next = dcmo_pkg::ST_DIVIDE;
                if (inner_reg)
                begin
                    if (acc_reg == '0)
                    begin
                        rem_next = qn_reg;
                        exp_next = exp_reg + EXP_BITS'(1);
                    end
                    else
                    begin
                        prod_next  = prod_scaled;
                        inner_next = 1'b0;
                        exp_next   = '0;
                        d_next     = d_following;
                        qn_next    = rem_reg;
                    end
                end
                else if (d_ext > qn_reg)
                begin
                    // The candidate passed the square root: finish up.
                    if (rem_reg > VALUE_BITS'(1))
                    begin
                        prod_next = prod_scaled;
                    end
                    state_next = dcmo_pkg::ST_DONE;
                end
                else if (acc_reg == '0)
                begin
                    rem_next   = qn_reg;
                    exp_next   = EXP_BITS'(1);
                    inner_next = 1'b1;
                end
                else
                begin
                    d_next  = d_following;
                    qn_next = rem_reg;
                end
            end
            dcmo_pkg::ST_DONE:
            begin
                if (result.ready)
                begin
                    state_next = dcmo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dcmo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dcmo_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        qn_reg    <= qn_next;
        acc_reg   <= acc_next;
        d_reg     <= d_next;
        exp_reg   <= exp_next;
        prod_reg  <= prod_next;
        cnt_reg   <= cnt_next;
        inner_reg <= inner_next;
    end

endmodule

// ===== hdl/dcmo_checker.sv =====
// Port-level checks of the divisor counter, bound to the core module.
// Depends on dcmo_pkg and the assertion macros in divisor_count_minus_one_core_assert.svh.
`include "divisor_count_minus_one_core_assert.svh"

module dcmo_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [dcmo_pkg::RESULT_BITS-1:0] out_data
);

    `DCMO_ASSERT_NEXT(a_out_valid_holds, out_valid && !out_ready, out_valid, "result word dropped while stalled")
    `DCMO_ASSERT_NEXT(a_out_data_holds, out_valid && !out_ready, $stable(out_data), "result word changed while stalled")
    `DCMO_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready && !out_valid, "core not busy after taking a word")
    `DCMO_ASSERT_SAME(a_no_input_while_result, out_valid, !in_ready, "input taken while a result waits")

endmodule

bind divisor_count_minus_one_core dcmo_checker u_dcmo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.divisors_less_one)
);
